// File: rtl/core/circular_fifo_with_replace_defines.svh
// assertion macros for the circular fifo with replace
`ifndef CIRCULAR_FIFO_WITH_REPLACE_DEFINES_SVH
`define CIRCULAR_FIFO_WITH_REPLACE_DEFINES_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define CFR_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("cfr assertion failed");

// next-cycle implication, checked out of reset
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("cfr assertion failed");

`else

`define CFR_ASSERT_IMPL(label, clk, rst, ante, cons)
`define CFR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// File: rtl/core/cfr_pkg.sv
// types and codes shared by the circular fifo with replace
package cfr_pkg;

   localparam int unsigned FIELD_WIDTH = 32;
   localparam int unsigned OCC_WIDTH   = 8;

   typedef enum logic [1:0] {
      ACT_ENQ  = 2'd0,
      ACT_DEQ  = 2'd1,
      ACT_REPL = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      STS_OK       = 2'd0,
      STS_FULL     = 2'd1,
      STS_EMPTY    = 2'd2,
      STS_NO_MATCH = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DEQ  = 3'b010,
      ST_SCAN = 3'b100
   } state_type;

endpackage

// File: rtl/core/cfr_ram.sv
// generic single-port-write, single-port-read ram with registered read
module cfr_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 128
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/circular_fifo_with_replace.sv
// Circular FIFO of signed words with replace-first-match, storage in one RAM.
// A request is taken when the block is idle and its result register is empty
// or being emptied in the same cycle. Enqueue, refused requests, a replace on
// an empty queue and the unused action code give their result in the cycle
// after acceptance; dequeue first passes through the DEQ state, as it waits for
// the RAM's registered read, and then loads its result. Replace on a non-empty
// queue walks the stored words from oldest to newest, one RAM read per cycle,
// and loads its result at the first match or after the newest word. Items are
// handled one at a time. The storage RAM needs no clearing after reset, since
// only words that were written are ever read.
module circular_fifo_with_replace #(
   parameter int unsigned DEPTH      = 128,
   parameter int unsigned DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic signed [cfr_pkg::FIELD_WIDTH-1:0] req_value,
   input  logic signed [cfr_pkg::FIELD_WIDTH-1:0] req_new_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [cfr_pkg::FIELD_WIDTH-1:0] rsp_read_value,
   output logic [1:0]  rsp_status,
   output logic [cfr_pkg::OCC_WIDTH-1:0] rsp_occupancy,
   output logic        rsp_is_empty,
   output logic        rsp_is_full
);

`include "circular_fifo_with_replace_defines.svh"

   localparam int unsigned AW = $clog2(DEPTH);
   localparam int unsigned CW = $clog2(DEPTH + 1);
   localparam int unsigned FW = cfr_pkg::FIELD_WIDTH;

   function automatic logic [AW-1:0] next_slot(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   cfr_pkg::state_type  state_ff, state_in;
   logic [AW-1:0]       head_ff, head_in;
   logic [AW-1:0]       tail_ff, tail_in;
   logic [CW-1:0]       count_ff, count_in;
   logic [AW-1:0]       scan_addr_ff, scan_addr_in;
   logic [CW-1:0]       scan_left_ff, scan_left_in;
   logic [DATA_WIDTH-1:0] match_ff, match_in;
   logic [DATA_WIDTH-1:0] new_ff, new_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic signed [FW-1:0] rsp_read_ff;
   cfr_pkg::status_type rsp_status_ff;
   logic [cfr_pkg::OCC_WIDTH-1:0] rsp_occ_ff;
   logic                rsp_empty_ff;
   logic                rsp_full_ff;

   logic                req_fire;
   logic                rsp_load;
   cfr_pkg::status_type status_nx;
   logic signed [FW-1:0] read_nx;
   logic [DATA_WIDTH-1:0] in_word;

   logic                wr_en;
   logic [AW-1:0]       wr_addr;
   logic [DATA_WIDTH-1:0] wr_data;
   logic [AW-1:0]       rd_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   cfr_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_storage (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == cfr_pkg::ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign in_word   = DATA_WIDTH'($unsigned(req_value));

   // idle reads the head for a dequeue or the first word of a walk
   assign rd_addr = (state_ff == cfr_pkg::ST_SCAN) ? next_slot(scan_addr_ff) : head_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      scan_addr_in = scan_addr_ff;
      scan_left_in = scan_left_ff;
      match_in     = match_ff;
      new_in       = new_ff;
      wr_en        = 1'b0;
      wr_addr      = tail_ff;
      wr_data      = in_word;
      rsp_load     = 1'b0;
      status_nx    = cfr_pkg::STS_OK;
      read_nx      = '0;
      case (state_ff)
         cfr_pkg::ST_IDLE: begin
            if (req_fire) begin
               case (req_action)
                  cfr_pkg::ACT_ENQ: begin
                     rsp_load = 1'b1;
                     if (count_ff == CW'(DEPTH)) begin
                        status_nx = cfr_pkg::STS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        tail_in  = next_slot(tail_ff);
                        count_in = count_ff + 1'b1;
                     end
                  end
                  cfr_pkg::ACT_DEQ: begin
                     if (count_ff == '0) begin
                        rsp_load  = 1'b1;
                        status_nx = cfr_pkg::STS_EMPTY;
                     end else begin
                        head_in  = next_slot(head_ff);
                        count_in = count_ff - 1'b1;
                        state_in = cfr_pkg::ST_DEQ;
                     end
                  end
                  cfr_pkg::ACT_REPL: begin
                     match_in = in_word;
                     new_in   = DATA_WIDTH'($unsigned(req_new_value));
                     if (count_ff == '0) begin
                        rsp_load  = 1'b1;
                        status_nx = cfr_pkg::STS_NO_MATCH;
                     end else begin
                        scan_addr_in = head_ff;
                        scan_left_in = count_ff;
                        state_in     = cfr_pkg::ST_SCAN;
                     end
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         cfr_pkg::ST_DEQ: begin
            rsp_load = 1'b1;
            read_nx  = FW'(signed'(rd_data));
            state_in = cfr_pkg::ST_IDLE;
         end
         cfr_pkg::ST_SCAN: begin
            // rd_data holds the word at scan_addr_ff
            if (rd_data == match_ff) begin
               wr_en    = 1'b1;
               wr_addr  = scan_addr_ff;
               wr_data  = new_ff;
               rsp_load = 1'b1;
               state_in = cfr_pkg::ST_IDLE;
            end else if (scan_left_ff == CW'(1)) begin
               rsp_load  = 1'b1;
               status_nx = cfr_pkg::STS_NO_MATCH;
               state_in  = cfr_pkg::ST_IDLE;
            end else begin
               scan_addr_in = next_slot(scan_addr_ff);
               scan_left_in = scan_left_ff - 1'b1;
            end
         end
         default: begin
            state_in = cfr_pkg::ST_IDLE;
         end
      endcase
      rsp_valid_in = rsp_load || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cfr_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         scan_addr_ff <= '0;
         scan_left_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         scan_addr_ff <= scan_addr_in;
         scan_left_ff <= scan_left_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      match_ff <= match_in;
      new_ff   <= new_in;
      if (rsp_load) begin
         rsp_read_ff   <= read_nx;
         rsp_status_ff <= status_nx;
         rsp_occ_ff    <= cfr_pkg::OCC_WIDTH'(count_in);
         rsp_empty_ff  <= (count_in == '0);
         rsp_full_ff   <= (count_in == CW'(DEPTH));
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_read_value = rsp_read_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_occupancy  = rsp_occ_ff;
   assign rsp_is_empty   = rsp_empty_ff;
   assign rsp_is_full    = rsp_full_ff;

   // a result never lands on one still waiting to be taken
   `CFR_ASSERT_IMPL(a_no_rsp_overwrite, clock, reset, rsp_load, !rsp_valid_ff || rsp_ready)
   // pointers agree with the fill count
   `CFR_ASSERT_IMPL(a_ptr_count, clock, reset, head_ff == tail_ff, count_ff == '0 || count_ff == CW'(DEPTH))
   `CFR_ASSERT_IMPL(a_count_range, clock, reset, 1'b1, count_ff <= CW'(DEPTH))
   // a walk always has a word left to check and no more than the queue holds
   `CFR_ASSERT_IMPL(a_scan_left, clock, reset, state_ff == cfr_pkg::ST_SCAN, scan_left_ff != '0 && scan_left_ff <= count_ff)
   // a dequeue result follows its read in the next cycle
   `CFR_ASSERT_NEXT(a_deq_done, clock, reset, state_ff == cfr_pkg::ST_DEQ, rsp_valid_ff)

endmodule

// File: tb/sv/circular_fifo_with_replace_tb.sv
// self-checking testbench for the circular fifo with replace
module circular_fifo_with_replace_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH      = 128;
   localparam int SLOT_BITS  = $clog2(DEPTH);
   localparam int RUN_LIMIT  = 1000000;
   localparam int HOLD_AFTER = 60;
   localparam int HOLD_LEN   = 300;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   typedef struct {
      logic [1:0]         action;
      logic signed [31:0] value;
      logic signed [31:0] new_value;
      bit                 drain_mark;
   } request_type;

   typedef struct {
      logic signed [31:0]  read_value;
      cfr_pkg::status_type status;
      logic [7:0]          occupancy;
      logic                is_empty;
      logic                is_full;
   } response_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_action = cfr_pkg::ACT_ENQ;
   logic signed [31:0] req_value = '0;
   logic signed [31:0] req_new_value = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic signed [31:0] rsp_read_value;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_occupancy;
   logic        rsp_is_empty;
   logic        rsp_is_full;

   // predictor state
   logic signed [31:0]   ring [DEPTH];
   logic [SLOT_BITS-1:0] head_slot = '0;
   logic [SLOT_BITS-1:0] tail_slot = '0;
   int                   fill_level = 0;

   request_type  request_plan [$];
   response_type pending_responses [$];
   logic signed [31:0] word_pool [16];

   logic req_fire = 1'b0;
   bit   draining = 1'b0;
   bit   hold_done = 1'b0;
   int   gap_left = 0;
   int   stall_left = 0;
   int   hold_left = 0;
   int   responses_seen = 0;
   int   error_count = 0;
   int   cycle_count = 0;

   circular_fifo_with_replace dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_action     (req_action),
      .req_value      (req_value),
      .req_new_value  (req_new_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_read_value (rsp_read_value),
      .rsp_status     (rsp_status),
      .rsp_occupancy  (rsp_occupancy),
      .rsp_is_empty   (rsp_is_empty),
      .rsp_is_full    (rsp_is_full)
   );

   always #2 clock = ~clock;

   function automatic response_type predict_response(logic [1:0] act, logic signed [31:0] word,
                                                     logic signed [31:0] repl);
      response_type         r;
      logic [SLOT_BITS-1:0] slot;
      bit                   found;
      r.read_value = '0;
      r.status     = cfr_pkg::STS_OK;
      case (act)
         cfr_pkg::ACT_ENQ: begin
            if (fill_level >= DEPTH) begin
               r.status = cfr_pkg::STS_FULL;
            end else begin
               ring[tail_slot] = word;
               tail_slot++;
               fill_level++;
            end
         end
         cfr_pkg::ACT_DEQ: begin
            if (fill_level == 0) begin
               r.status = cfr_pkg::STS_EMPTY;
            end else begin
               r.read_value = ring[head_slot];
               head_slot++;
               fill_level--;
            end
         end
         cfr_pkg::ACT_REPL: begin
            // walk oldest to newest, first match only
            r.status = cfr_pkg::STS_NO_MATCH;
            slot = head_slot;
            found = 1'b0;
            for (int k = 0; k < fill_level && !found; k++) begin
               if (ring[slot] == word) begin
                  ring[slot] = repl;
                  r.status = cfr_pkg::STS_OK;
                  found = 1'b1;
               end
               slot++;
            end
         end
         default: ;
      endcase
      r.occupancy = fill_level[7:0];
      r.is_empty  = (fill_level == 0);
      r.is_full   = (fill_level >= DEPTH);
      return r;
   endfunction

   // idle length: mostly none or short, now and then long, none at all in steady stretches
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if ((cycle_count / 256) % 4 == 3) return 0;
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic signed [31:0] pick_word();
      if ($urandom_range(0, 9) < 7) return word_pool[$urandom_range(0, 15)];
      return $urandom;
   endfunction

   function automatic void add_req(logic [1:0] act, logic signed [31:0] word,
                                   logic signed [31:0] repl);
      request_type q;
      q.action     = act;
      q.value      = word;
      q.new_value  = repl;
      q.drain_mark = 1'b0;
      request_plan.push_back(q);
   endfunction

   function automatic void add_pause();
      request_type q;
      q.action     = cfr_pkg::ACT_ENQ;
      q.value      = '0;
      q.new_value  = '0;
      q.drain_mark = 1'b1;
      request_plan.push_back(q);
   endfunction

   function automatic void add_burst(int n, logic [1:0] act);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 7) == 0) add_req(cfr_pkg::ACT_REPL, pick_word(), pick_word());
         add_req(act, pick_word(), $urandom);
      end
   endfunction

   function automatic void add_mixed(int n, int enq_weight);
      int r;
      for (int i = 0; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < enq_weight) add_req(cfr_pkg::ACT_ENQ, pick_word(), $urandom);
         else if (r < 70) add_req(cfr_pkg::ACT_DEQ, $urandom, $urandom);
         else if (r < 95) add_req(cfr_pkg::ACT_REPL, pick_word(), pick_word());
         else add_req(ACT_UNUSED, $urandom, $urandom);
      end
   endfunction

   // request side: handshake tracking and prediction, result side: checking
   always @(posedge clock) begin
      response_type want;
      req_fire <= !reset && req_valid && req_ready;
      if (!reset && req_valid && req_ready)
         pending_responses.push_back(predict_response(req_action, req_value, req_new_value));
      if (!reset && rsp_valid && rsp_ready) begin
         responses_seen++;
         if (pending_responses.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("unexpected word: read %h status %0d occ %0d empty %b full %b",
                        rsp_read_value, rsp_status, rsp_occupancy, rsp_is_empty, rsp_is_full);
         end else begin
            want = pending_responses.pop_front();
            if (rsp_read_value !== want.read_value || rsp_status !== want.status ||
                rsp_occupancy !== want.occupancy || rsp_is_empty !== want.is_empty ||
                rsp_is_full !== want.is_full) begin
               error_count++;
               if (error_count <= 10)
                  $display("mismatch on word %0d: exp read %h sts %0d occ %0d e %b f %b,",
                           responses_seen, want.read_value, want.status, want.occupancy,
                           want.is_empty, want.is_full,
                           " got read %h sts %0d occ %0d e %b f %b",
                           rsp_read_value, rsp_status, rsp_occupancy, rsp_is_empty,
                           rsp_is_full);
            end
         end
      end
   end

   // sender
   always @(negedge clock) begin
      request_type q;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_fire) begin
         if (draining) begin
            if (pending_responses.size() == 0) draining = 1'b0;
            req_valid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (request_plan.size() > 0) begin
            q = request_plan.pop_front();
            if (q.drain_mark) begin
               draining = 1'b1;
               req_valid <= 1'b0;
            end else begin
               req_action    <= q.action;
               req_value     <= q.value;
               req_new_value <= q.new_value;
               req_valid     <= 1'b1;
               gap_left = idle_len();
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver, with one long hold-off so the block backs up its input
   always @(negedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (!hold_done && responses_seen >= HOLD_AFTER) begin
         hold_done = 1'b1;
         hold_left = HOLD_LEN;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
         stall_left = idle_len();
         rsp_ready <= (stall_left == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= RUN_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      word_pool[0] = 32'sh8000_0000;
      word_pool[1] = 32'sh7fff_ffff;
      word_pool[2] = 32'sh0000_0000;
      word_pool[3] = -32'sd1;
      for (int i = 4; i < 16; i++) word_pool[i] = $urandom;

      // refused and ignored requests on an empty queue
      add_req(cfr_pkg::ACT_DEQ, 32'sh7fff_ffff, -32'sd1);
      add_req(cfr_pkg::ACT_REPL, 32'sh0000_0000, 32'sh7fff_ffff);
      add_req(ACT_UNUSED, -32'sd1, -32'sd1);
      // extremes, with a duplicate to check that only the first match changes
      add_req(cfr_pkg::ACT_ENQ, 32'sh8000_0000, -32'sd1);
      add_req(cfr_pkg::ACT_ENQ, 32'sh7fff_ffff, 32'sh0000_0000);
      add_req(cfr_pkg::ACT_ENQ, 32'sh0000_0000, 32'sh8000_0000);
      add_req(cfr_pkg::ACT_ENQ, -32'sd1, 32'sh7fff_ffff);
      add_req(cfr_pkg::ACT_ENQ, 32'sh7fff_ffff, -32'sd1);
      add_req(cfr_pkg::ACT_REPL, 32'sh7fff_ffff, 32'sh8000_0000);
      add_req(cfr_pkg::ACT_REPL, 32'sh0001_2345, 32'sh0000_0000);
      add_req(cfr_pkg::ACT_REPL, -32'sd1, 32'sh5555_5555);
      add_req(ACT_UNUSED, 32'sh7fff_ffff, 32'sh8000_0000);
      for (int i = 0; i < 5; i++) add_req(cfr_pkg::ACT_DEQ, 32'sh0000_0000, 32'sh0000_0000);
      add_req(cfr_pkg::ACT_DEQ, -32'sd1, -32'sd1);
      add_req(cfr_pkg::ACT_REPL, -32'sd1, 32'sh2aaa_aaaa);
      add_pause();

      // fill past full, drift down, drain past empty, refill across the wrap
      add_burst(140, cfr_pkg::ACT_ENQ);
      add_pause();
      add_mixed(250, 30);
      add_burst(140, cfr_pkg::ACT_DEQ);
      add_burst(140, cfr_pkg::ACT_ENQ);
      add_mixed(250, 45);

      repeat (6) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      while (request_plan.size() != 0 || req_valid || draining ||
             pending_responses.size() != 0)
         @(posedge clock);
      repeat (DEPTH + 8) @(posedge clock);
      if (error_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule
